// File: design/scpp_pkg.sv
package scpp_pkg;

   // frame header bytes
   localparam logic [7:0] HDR_FIRST  = 8'hFF;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] FOOTER     = 8'h00;
   localparam logic [7:0] REPLY_CMD  = 8'h00;

   // reply length bytes
   localparam logic [7:0] LEN_WORD  = 8'h05;
   localparam logic [7:0] LEN_EMPTY = 8'h01;

   // command codes
   localparam logic [7:0] CMD_VERSION = 8'h13;
   localparam logic [7:0] CMD_BAUD    = 8'h00;
   localparam logic [7:0] CMD_LOCATE  = 8'h01;
   localparam logic [7:0] CMD_ORIGIN  = 8'h02;
   localparam logic [7:0] CMD_CUBE    = 8'h04;
   localparam logic [7:0] CMD_TESTS   = 8'h08;

   // configuration register indexes
   localparam logic [1:0] CSR_VERSION = 2'd0;
   localparam logic [1:0] CSR_BAUD    = 2'd1;
   localparam logic [1:0] CSR_TEST    = 2'd2;

   // configuration reset values
   localparam logic [31:0] VERSION_RESET = 32'd1;
   localparam logic [31:0] BAUD_RESET    = 32'd115200;
   localparam logic [31:0] TEST_RESET    = 32'd200;

   // first payload position in a frame
   localparam int PAYLOAD_START = 4;

   // one reply frame handed from the parser to the framer
   typedef struct packed {
      logic        with_word;
      logic [31:0] word;
      logic        position_valid;
      logic [31:0] position_value;
      logic        cube_valid;
      logic [31:0] cube_value;
      logic        mode;
      logic        update_pending;
      logic        origin_requested;
   } reply_type;

endpackage

// File: design/scpp_reply.sv
module scpp_reply (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  scpp_pkg::reply_type load_data,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_tx_last,
   output logic               rsp_position_valid,
   output logic [31:0]        rsp_position_value,
   output logic               rsp_cube_valid,
   output logic [31:0]        rsp_cube_value,
   output logic               rsp_mode,
   output logic               rsp_update_pending,
   output logic               rsp_origin_requested
);

   logic                busy_ff, busy_in;
   logic [3:0]          index_ff, index_in;
   scpp_pkg::reply_type frame_ff;
   logic [3:0]          last_index;
   logic                last;
   logic                take;

   // position of the footer byte
   assign last_index = frame_ff.with_word ? 4'd8 : 4'd4;
   assign last       = (index_ff == last_index);
   assign take       = busy_ff && !rsp_stall;

   // byte counter and busy flag
   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      if (load) begin
         busy_in  = 1'b1;
         index_in = 4'd0;
      end else if (take) begin
         if (last) begin
            busy_in = 1'b0;
         end
         index_in = index_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   // reply contents held for the whole frame
   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= load_data;
      end
   end

   // byte select
   always_comb begin
      if (last) begin
         rsp_tx_byte = scpp_pkg::FOOTER;
      end else begin
         case (index_ff)
            4'd0:    rsp_tx_byte = scpp_pkg::HDR_FIRST;
            4'd1:    rsp_tx_byte = scpp_pkg::HDR_SECOND;
            4'd2:    rsp_tx_byte = frame_ff.with_word ? scpp_pkg::LEN_WORD
                                                      : scpp_pkg::LEN_EMPTY;
            4'd3:    rsp_tx_byte = scpp_pkg::REPLY_CMD;
            default: rsp_tx_byte = frame_ff.word[8*index_ff[1:0] +: 8];
         endcase
      end
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = busy_ff;
   assign rsp_tx_last          = last;
   assign rsp_position_valid   = frame_ff.position_valid;
   assign rsp_position_value   = frame_ff.position_value;
   assign rsp_cube_valid       = frame_ff.cube_valid;
   assign rsp_cube_value       = frame_ff.cube_value;
   assign rsp_mode             = frame_ff.mode;
   assign rsp_update_pending   = frame_ff.update_pending;
   assign rsp_origin_requested = frame_ff.origin_requested;

   // a new frame never lands on one still being sent
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff)
      else $error("reply loaded while framer busy");

   // counter never runs past the footer
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (index_ff <= last_index))
      else $error("reply byte counter out of range");

   // taking the footer ends the frame
   a_footer_ends: assert property (@(posedge clock) disable iff (reset)
      (take && last && !load) |=> !busy_ff)
      else $error("framer still busy after footer");

   // a frame always opens with the first header byte
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_tx_byte == scpp_pkg::HDR_FIRST))
      else $error("reply frame does not start with header");

endmodule

// File: design/serial_command_packet_parser.sv
// channel  | ports                  | handshake           | payload
// request  | req_*                  | req_valid/req_stall | rx_byte
// reply    | rsp_*                  | rsp_valid/rsp_stall | tx_byte, tx_last, side effects
// config   | csr_*                  | csr_valid/csr_ready | csr_index, csr_wdata
//
// every received byte is parsed in the cycle it is accepted; one per clock unless req_stall holds it
// a checksum byte that completes a good frame loads the reply framer, which
// sends 5 or 9 bytes at one per cycle while rsp_stall is low; the request channel
// stalls a frame's final byte only while the previous reply is still being sent
// reset (synchronous) clears parser, flags, framer and registers to defaults
// csr writes are taken every cycle (csr_ready is always high)
module serial_command_packet_parser #(
   parameter int MAX_FRAME_BYTES = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic        rsp_position_valid,
   output logic [31:0] rsp_position_value,
   output logic        rsp_cube_valid,
   output logic [31:0] rsp_cube_value,
   output logic        rsp_mode,
   output logic        rsp_update_pending,
   output logic        rsp_origin_requested,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int PW      = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_MAX = MAX_FRAME_BYTES - 4;

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    command_ff, command_in;
   logic [7:0]    store_ff [4];
   logic          mode_ff, mode_in;
   logic          update_ff, update_in;
   logic          origin_ff, origin_in;
   logic [31:0]   version_ff, baud_ff, test_ff;

   logic                accept;
   logic                at_final;
   logic                store_write;
   logic                check_ok;
   logic                reply_fire;
   logic                busy;
   logic [31:0]         store_word;
   scpp_pkg::reply_type reply;

   assign accept     = req_valid && !req_stall;
   assign at_final   = (pos_ff >= PW'(scpp_pkg::PAYLOAD_START)) &&
                       (9'(pos_ff) == ({1'b0, length_ff} + 9'd3));
   assign req_stall  = busy && at_final;
   assign check_ok   = ({1'b0, req_rx_byte} == ({1'b0, command_ff} + 9'd1));
   assign store_word = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
   assign store_write = accept && !at_final &&
                        (pos_ff >= PW'(scpp_pkg::PAYLOAD_START)) &&
                        (pos_ff < PW'(scpp_pkg::PAYLOAD_START + 4));

   // frame parser
   always_comb begin
      pos_in     = pos_ff;
      length_in  = length_ff;
      command_in = command_ff;
      if (accept) begin
         if (pos_ff == PW'(0)) begin
            pos_in = (req_rx_byte == scpp_pkg::HDR_FIRST) ? PW'(1) : PW'(0);
         end else if (pos_ff == PW'(1)) begin
            pos_in = (req_rx_byte == scpp_pkg::HDR_SECOND) ? PW'(2) : PW'(0);
         end else if (pos_ff == PW'(2)) begin
            length_in = req_rx_byte;
            pos_in    = PW'(3);
         end else if (pos_ff == PW'(3)) begin
            command_in = req_rx_byte;
            if (length_ff == 8'd0 || length_ff > 8'(LEN_MAX)) begin
               pos_in = PW'(0);
            end else begin
               pos_in = PW'(4);
            end
         end else if (at_final) begin
            pos_in = PW'(0);
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   // command decode and side effects
   always_comb begin
      reply_fire = 1'b0;
      mode_in    = mode_ff;
      update_in  = update_ff;
      origin_in  = origin_ff;
      reply      = '0;
      unique case (command_ff)
         scpp_pkg::CMD_VERSION: begin
            reply_fire     = (length_ff == 8'd1);
            reply.with_word = 1'b1;
            reply.word     = version_ff;
         end
         scpp_pkg::CMD_BAUD: begin
            reply_fire     = (length_ff == 8'd1);
            reply.with_word = 1'b1;
            reply.word     = baud_ff;
         end
         scpp_pkg::CMD_LOCATE: begin
            reply_fire           = (length_ff == 8'd5);
            reply.with_word      = 1'b1;
            reply.word           = store_word;
            reply.position_valid = 1'b1;
            reply.position_value = store_word;
         end
         scpp_pkg::CMD_ORIGIN: begin
            reply_fire = (length_ff == 8'd1);
         end
         scpp_pkg::CMD_CUBE: begin
            reply_fire       = (length_ff == 8'd5);
            reply.cube_valid = 1'b1;
            reply.cube_value = store_word;
         end
         scpp_pkg::CMD_TESTS: begin
            reply_fire      = (length_ff == 8'd1);
            reply.with_word = 1'b1;
            reply.word      = test_ff;
         end
         default: begin
            reply_fire = 1'b0;
         end
      endcase
      reply_fire = reply_fire && accept && at_final && check_ok;
      if (reply_fire) begin
         case (command_ff)
            scpp_pkg::CMD_LOCATE: begin
               mode_in   = 1'b1;
               update_in = 1'b1;
            end
            scpp_pkg::CMD_ORIGIN: begin
               origin_in = 1'b1;
               update_in = 1'b1;
            end
            scpp_pkg::CMD_TESTS: begin
               mode_in = 1'b0;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      reply.mode             = mode_in;
      reply.update_pending   = update_in;
      reply.origin_requested = origin_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         length_ff  <= '0;
         command_ff <= '0;
         mode_ff    <= 1'b0;
         update_ff  <= 1'b0;
         origin_ff  <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         mode_ff    <= mode_in;
         update_ff  <= update_in;
         origin_ff  <= origin_in;
      end
   end

   // payload bytes, first four only
   always_ff @(posedge clock) begin
      if (store_write) begin
         store_ff[pos_ff[1:0]] <= req_rx_byte;
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= scpp_pkg::VERSION_RESET;
         baud_ff    <= scpp_pkg::BAUD_RESET;
         test_ff    <= scpp_pkg::TEST_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scpp_pkg::CSR_VERSION: version_ff <= csr_wdata;
            scpp_pkg::CSR_BAUD:    baud_ff    <= csr_wdata;
            scpp_pkg::CSR_TEST:    test_ff    <= csr_wdata;
            default:               version_ff <= version_ff;
         endcase
      end
   end

   // reply framer
   scpp_reply u_reply (
      .clock                (clock),
      .reset                (reset),
      .load                 (reply_fire),
      .load_data            (reply),
      .busy                 (busy),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_tx_byte          (rsp_tx_byte),
      .rsp_tx_last          (rsp_tx_last),
      .rsp_position_valid   (rsp_position_valid),
      .rsp_position_value   (rsp_position_value),
      .rsp_cube_valid       (rsp_cube_valid),
      .rsp_cube_value       (rsp_cube_value),
      .rsp_mode             (rsp_mode),
      .rsp_update_pending   (rsp_update_pending),
      .rsp_origin_requested (rsp_origin_requested)
   );

   // parser never runs past the end of the buffer
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      9'(pos_ff) < 9'(MAX_FRAME_BYTES))
      else $error("parse position beyond frame buffer");

   // an accepted final byte always returns the parser to the start
   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && at_final) |=> (pos_ff == PW'(0)))
      else $error("parser did not restart after frame");

   // origin request always raises the update flag too
   a_origin_update: assert property (@(posedge clock) disable iff (reset)
      origin_ff |-> update_ff)
      else $error("origin flag set without update flag");

endmodule

// File: bench/serial_command_packet_parser_test.sv
module serial_command_packet_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT = 18;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;

   // one reply byte with its side-effect fields
   typedef struct {
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        position_valid;
      logic [31:0] position_value;
      logic        cube_valid;
      logic [31:0] cube_value;
      logic        mode;
      logic        update_pending;
      logic        origin_requested;
   } reply_byte_type;

   // one received byte waiting to be sent, optionally held until replies drain
   typedef struct {
      logic [7:0] data;
      bit         hold;
   } rx_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_position_valid;
   logic [31:0] rsp_position_value;
   logic        rsp_cube_valid;
   logic [31:0] rsp_cube_value;
   logic        rsp_mode;
   logic        rsp_update_pending;
   logic        rsp_origin_requested;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = scpp_pkg::CSR_VERSION;
   logic [31:0] csr_wdata = 32'h0;

   serial_command_packet_parser #(.MAX_FRAME_BYTES(FRAME_LIMIT)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_position_valid(rsp_position_valid),
      .rsp_position_value(rsp_position_value),
      .rsp_cube_valid(rsp_cube_valid),
      .rsp_cube_value(rsp_cube_value),
      .rsp_mode(rsp_mode),
      .rsp_update_pending(rsp_update_pending),
      .rsp_origin_requested(rsp_origin_requested),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // bench-side copy of the parser state and registers
   int          parse_pos = 0;
   int          len_seen = 0;
   logic [7:0]  cmd_seen = 8'h00;
   logic [7:0]  payload_bytes [4];
   logic        mode_now = 1'b0;
   logic        update_now = 1'b0;
   logic        origin_now = 1'b0;
   logic [31:0] version_cfg = scpp_pkg::VERSION_RESET;
   logic [31:0] baud_cfg = scpp_pkg::BAUD_RESET;
   logic [31:0] test_cfg = scpp_pkg::TEST_RESET;

   rx_entry_type   rx_plan [$];
   reply_byte_type expected_tx [$];
   logic [7:0]     known_cmds [6] = '{scpp_pkg::CMD_VERSION, scpp_pkg::CMD_BAUD,
                                      scpp_pkg::CMD_LOCATE, scpp_pkg::CMD_ORIGIN,
                                      scpp_pkg::CMD_CUBE, scpp_pkg::CMD_TESTS};

   int  cycle_count = 0;
   bit  byte_taken = 1'b0;
   int  bytes_queued = 0;
   int  bytes_sent = 0;
   int  replies_expected = 0;
   int  reply_bytes_checked = 0;
   int  csr_writes = 0;
   int  mismatch_count = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  stall_run = 0;

   // stretches with no gaps and no stalls
   function automatic bit quiet_window();
      return (cycle_count % 400) < 60;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
   endtask

   // build one reply frame and queue its bytes
   task automatic queue_reply(input bit with_word, input logic [31:0] word,
                              input bit pos_ok, input logic [31:0] pos_val,
                              input bit cube_ok, input logic [31:0] cube_val);
      logic [7:0]     frame [9];
      int             n;
      int             i;
      reply_byte_type r;
      frame[0] = scpp_pkg::HDR_FIRST;
      frame[1] = scpp_pkg::HDR_SECOND;
      frame[2] = with_word ? scpp_pkg::LEN_WORD : scpp_pkg::LEN_EMPTY;
      frame[3] = scpp_pkg::REPLY_CMD;
      n = 4;
      if (with_word) begin
         for (i = 0; i < 4; i++)
            frame[4'(4 + i)] = word[8*i +: 8];
         n = 8;
      end
      frame[4'(n)] = scpp_pkg::FOOTER;
      n = n + 1;
      for (i = 0; i < n; i++) begin
         r.tx_byte = frame[4'(i)];
         r.tx_last = (i == n - 1);
         r.position_valid = pos_ok;
         r.position_value = pos_ok ? pos_val : 32'h0;
         r.cube_valid = cube_ok;
         r.cube_value = cube_ok ? cube_val : 32'h0;
         r.mode = mode_now;
         r.update_pending = update_now;
         r.origin_requested = origin_now;
         expected_tx.push_back(r);
      end
      replies_expected++;
   endtask

   // decode a frame that passed its checksum
   task automatic run_command();
      logic [31:0] w;
      w = {payload_bytes[3], payload_bytes[2], payload_bytes[1], payload_bytes[0]};
      case (cmd_seen)
         scpp_pkg::CMD_VERSION: begin
            if (len_seen == 1) queue_reply(1'b1, version_cfg, 1'b0, 32'h0, 1'b0, 32'h0);
         end
         scpp_pkg::CMD_BAUD: begin
            if (len_seen == 1) queue_reply(1'b1, baud_cfg, 1'b0, 32'h0, 1'b0, 32'h0);
         end
         scpp_pkg::CMD_LOCATE: begin
            if (len_seen == 5) begin
               mode_now = 1'b1;
               update_now = 1'b1;
               queue_reply(1'b1, w, 1'b1, w, 1'b0, 32'h0);
            end
         end
         scpp_pkg::CMD_ORIGIN: begin
            if (len_seen == 1) begin
               origin_now = 1'b1;
               update_now = 1'b1;
               queue_reply(1'b0, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
            end
         end
         scpp_pkg::CMD_CUBE: begin
            if (len_seen == 5) queue_reply(1'b0, 32'h0, 1'b0, 32'h0, 1'b1, w);
         end
         scpp_pkg::CMD_TESTS: begin
            if (len_seen == 1) begin
               mode_now = 1'b0;
               queue_reply(1'b1, test_cfg, 1'b0, 32'h0, 1'b0, 32'h0);
            end
         end
         default: ;
      endcase
   endtask

   // frame parser, one received byte at a time
   task automatic parse_rx_byte(input logic [7:0] b);
      int p;
      p = parse_pos;
      if (p == 0) begin
         if (b == scpp_pkg::HDR_FIRST) parse_pos = 1;
      end else if (p == 1) begin
         parse_pos = (b == scpp_pkg::HDR_SECOND) ? 2 : 0;
      end else if (p == 2) begin
         len_seen = int'(b);
         parse_pos = 3;
      end else if (p == 3) begin
         cmd_seen = b;
         parse_pos = (len_seen == 0 || len_seen + 4 > FRAME_LIMIT) ? 0 : 4;
      end else if (p == len_seen + 3) begin
         parse_pos = 0;
         // checksum is cmd + 1 with no wrap
         if (int'(b) == int'(cmd_seen) + 1) run_command();
      end else begin
         if (p - 4 < 4) payload_bytes[2'(p - 4)] = b;
         parse_pos = (p + 1) & 31;
      end
   endtask

   // predictor and checker, sampled at the rising edge
   always @(posedge clock) begin
      reply_byte_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d with %0d reply bytes outstanding", cycle_count,
                  expected_tx.size());
         $display("FAIL serial_command_packet_parser");
         $finish;
      end else if (reset) begin
         byte_taken = 1'b0;
      end else begin
         byte_taken = req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               scpp_pkg::CSR_VERSION: version_cfg = csr_wdata;
               scpp_pkg::CSR_BAUD:    baud_cfg = csr_wdata;
               scpp_pkg::CSR_TEST:    test_cfg = csr_wdata;
               default: ;
            endcase
            csr_writes++;
         end
         if (byte_taken) begin
            bytes_sent++;
            parse_rx_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tx.size() == 0) begin
               flag_mismatch("unexpected reply byte", 32'h0, {24'h0, rsp_tx_byte});
            end else begin
               want = expected_tx.pop_front();
               reply_bytes_checked++;
               if (rsp_tx_byte !== want.tx_byte)
                  flag_mismatch("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
               if (rsp_tx_last !== want.tx_last)
                  flag_mismatch("tx_last", 32'(want.tx_last), 32'(rsp_tx_last));
               if (rsp_position_valid !== want.position_valid)
                  flag_mismatch("position_valid", 32'(want.position_valid),
                                32'(rsp_position_valid));
               if (rsp_position_value !== want.position_value)
                  flag_mismatch("position_value", want.position_value, rsp_position_value);
               if (rsp_cube_valid !== want.cube_valid)
                  flag_mismatch("cube_valid", 32'(want.cube_valid), 32'(rsp_cube_valid));
               if (rsp_cube_value !== want.cube_value)
                  flag_mismatch("cube_value", want.cube_value, rsp_cube_value);
               if (rsp_mode !== want.mode)
                  flag_mismatch("mode", 32'(want.mode), 32'(rsp_mode));
               if (rsp_update_pending !== want.update_pending)
                  flag_mismatch("update_pending", 32'(want.update_pending),
                                32'(rsp_update_pending));
               if (rsp_origin_requested !== want.origin_requested)
                  flag_mismatch("origin_requested", 32'(want.origin_requested),
                                32'(rsp_origin_requested));
            end
         end
      end
   end

   // request driver: bursts with random gaps, optional hold until replies drain
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (gap_left > 0 && !quiet_window()) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_plan.size() == 0 || (rx_plan[0].hold && expected_tx.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            req_rx_byte <= rx_plan[0].data;
            req_valid <= 1'b1;
            rx_plan.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left = $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // reply stall pattern: random, long runs, and periodic in turn
   always @(negedge clock) begin
      if (reset || quiet_window()) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((cycle_count / 97) % 3)
            0: rsp_stall <= ($urandom_range(0, 3) == 0);
            1: begin
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
                  if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
               end
            end
            default: rsp_stall <= cycle_count[2];
         endcase
      end
   end

   task automatic push_rx(input logic [7:0] b, input bit hold);
      rx_entry_type e;
      e.data = b;
      e.hold = hold;
      rx_plan.push_back(e);
      bytes_queued++;
   endtask

   // header, length, command, then payload and checksum when the length allows
   task automatic push_frame(input logic [7:0] cmd, input int len, input bit good_chk,
                             input int fill, input bit hold);
      logic [7:0] chk;
      int         i;
      push_rx(scpp_pkg::HDR_FIRST, hold);
      push_rx(scpp_pkg::HDR_SECOND, 1'b0);
      push_rx(8'(len), 1'b0);
      push_rx(cmd, 1'b0);
      if (len != 0 && len + 4 <= FRAME_LIMIT) begin
         for (i = 0; i < len - 1; i++)
            push_rx((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
         chk = cmd + 8'd1;
         if (!good_chk) chk = chk + 8'($urandom_range(1, 255));
         push_rx(chk, 1'b0);
      end
   endtask

   // mostly well-formed commands, the rest noise and broken frames
   task automatic add_random_frame();
      logic [7:0] cmd;
      int         need_len;
      int         pick;
      bit         hold;
      int         i;
      hold = ($urandom_range(0, 14) == 0);
      pick = $urandom_range(0, 99);
      cmd = known_cmds[3'($urandom_range(0, 5))];
      need_len = (cmd == scpp_pkg::CMD_LOCATE || cmd == scpp_pkg::CMD_CUBE) ? 5 : 1;
      if (pick < 66) begin
         push_frame(cmd, need_len, 1'b1, -1, hold);
      end else if (pick < 74) begin
         push_frame(cmd, need_len, 1'b0, -1, hold);
      end else if (pick < 79) begin
         push_frame(cmd, (need_len == 5) ? 1 : 5, 1'b1, -1, hold);
      end else if (pick < 86) begin
         for (i = 0; i < $urandom_range(1, 3); i++)
            push_rx(8'($urandom_range(0, 255)), hold);
      end else if (pick < 94) begin
         push_frame(8'($urandom_range(0, 255)), $urandom_range(0, 16),
                    bit'($urandom_range(0, 1)), -1, hold);
      end else begin
         push_rx(scpp_pkg::HDR_FIRST, hold);
         push_rx(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic run_random(input int n_bytes);
      int goal;
      goal = bytes_queued + n_bytes;
      while (bytes_queued < goal) add_random_frame();
   endtask

   // wait until every queued byte is taken and every reply byte has arrived
   task automatic drain_and_settle();
      while (bytes_sent != bytes_queued || expected_tx.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_words(input logic [31:0] v, input logic [31:0] b, input logic [31:0] t);
      write_csr(scpp_pkg::CSR_VERSION, v);
      write_csr(scpp_pkg::CSR_BAUD, b);
      write_csr(scpp_pkg::CSR_TEST, t);
   endtask

   // stimulus sequence
   initial begin
      payload_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // junk before a header, and a bad second byte that is not rescanned
      push_rx(8'h00, 1'b0);
      push_rx(8'h12, 1'b0);
      push_rx(scpp_pkg::HDR_FIRST, 1'b0);
      push_rx(scpp_pkg::HDR_FIRST, 1'b0);
      push_rx(scpp_pkg::HDR_SECOND, 1'b0);
      // each command with its required length, payload extremes
      push_frame(scpp_pkg::CMD_VERSION, 1, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_BAUD, 1, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_LOCATE, 5, 1'b1, 8'hFF, 1'b0);
      push_frame(scpp_pkg::CMD_ORIGIN, 1, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_CUBE, 5, 1'b1, 8'h00, 1'b0);
      push_frame(scpp_pkg::CMD_TESTS, 1, 1'b1, -1, 1'b1);
      push_frame(scpp_pkg::CMD_LOCATE, 5, 1'b1, 8'h00, 1'b0);
      push_frame(scpp_pkg::CMD_CUBE, 5, 1'b1, 8'hFF, 1'b0);
      // zero length and oversize lengths, then the largest length that fits
      push_frame(scpp_pkg::CMD_VERSION, 0, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_VERSION, FRAME_LIMIT - 3, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_VERSION, 255, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_LOCATE, FRAME_LIMIT - 4, 1'b1, -1, 1'b0);
      // bad checksum, unknown command, wrong length, command FF whose checksum wraps
      push_frame(scpp_pkg::CMD_VERSION, 1, 1'b0, -1, 1'b0);
      push_frame(8'h55, 1, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_VERSION, 5, 1'b1, -1, 1'b0);
      push_frame(8'hFF, 1, 1'b1, -1, 1'b0);
      // extra payload bytes past the stored four
      push_frame(scpp_pkg::CMD_CUBE, 9, 1'b1, -1, 1'b0);
      push_frame(scpp_pkg::CMD_TESTS, 1, 1'b1, -1, 1'b0);
      drain_and_settle();

      // random phases under several register settings
      set_words(32'h0, 32'h0, 32'h0);
      run_random(62);
      drain_and_settle();
      set_words(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(62);
      drain_and_settle();
      set_words($urandom, $urandom, $urandom);
      run_random(62);
      drain_and_settle();
      set_words(32'h8000_0001, $urandom, 32'h7FFF_FFFE);
      run_random(62);
      drain_and_settle();

      $display("covered %0d received bytes, %0d replies (%0d reply bytes checked)",
               bytes_sent, replies_expected, reply_bytes_checked);
      $display("across %0d register writes, %0d mismatches", csr_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS serial_command_packet_parser");
      end else begin
         $display("FAIL serial_command_packet_parser");
      end
      $finish;
   end

endmodule
